### sv/aet_pkg.sv
// ----------------------------------------------------------------------------
// aet_pkg
// shared types and constants of the arc-eager transition engine
// ----------------------------------------------------------------------------
package aet_pkg;

   localparam int MAX_WORDS_DEF   = 256;
   localparam int STACK_DEPTH_DEF = 256;

   typedef enum logic [2:0] {
      CMD_START  = 3'd0,
      CMD_SHIFT  = 3'd1,
      CMD_REDUCE = 3'd2,
      CMD_LEFT   = 3'd3,
      CMD_RIGHT  = 3'd4,
      CMD_QUERY  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] arc_label;
      logic [7:0] query_word;
   } req_type;

   typedef struct packed {
      logic       allow_shift;
      logic       allow_reduce;
      logic       allow_left_arc;
      logic       allow_right_arc;
      logic [8:0] stack_depth;
      logic [7:0] stack_top_word;
      logic [8:0] next_word_index;
      logic       input_done;
      logic       rejected;
      logic [7:0] query_head;
      logic       query_head_valid;
      logic [7:0] query_label;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic fetch;
      logic reply;
   } ctl_cmd_type;

endpackage

### sv/arc_eager_transition_engine.sv
// ----------------------------------------------------------------------------
// arc_eager_transition_engine
// arc-eager dependency transition engine: stack, input position, heads, labels
// ----------------------------------------------------------------------------
// the result strobe is registered from the reply state, after execute and fetch
// a new word is taken only in idle: execute with the registered stack read, fetch
//   for top reload and head/label read, reply into the output register, then idle
// reset clears the stack count, input position, input size, head marks and the
//   length register; the stack and head/label stores are not cleared
// each result is shown for one cycle only; the receiver cannot stall
module arc_eager_transition_engine #(
   parameter int MAX_WORDS   = aet_pkg::MAX_WORDS_DEF,
   parameter int STACK_DEPTH = aet_pkg::STACK_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  aet_pkg::req_type req_word,
   output logic             rsp_strobe,
   output aet_pkg::rsp_type rsp_word,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);

   aet_pkg::ctl_cmd_type ctl;

   aet_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl)
   );

   aet_datapath #(
      .MAX_WORDS   (MAX_WORDS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word)
   );

endmodule

### sv/aet_ctrl.sv
// ----------------------------------------------------------------------------
// aet_ctrl
// sequencer: capture, execute, fetch and reply steps for each word
// ----------------------------------------------------------------------------
module aet_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output aet_pkg::ctl_cmd_type ctl
);

   aet_pkg::state_type state_ff;
   aet_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aet_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aet_pkg::ST_IDLE: begin
            if (start) begin
               state_in = aet_pkg::ST_EXEC;
            end
         end
         aet_pkg::ST_EXEC:  state_in = aet_pkg::ST_FETCH;
         aet_pkg::ST_FETCH: state_in = aet_pkg::ST_REPLY;
         aet_pkg::ST_REPLY: state_in = aet_pkg::ST_IDLE;
         default:           state_in = aet_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy        = 1'b1;
      ctl.capture = 1'b0;
      ctl.execute = 1'b0;
      ctl.fetch   = 1'b0;
      ctl.reply   = 1'b0;
      case (state_ff)
         aet_pkg::ST_IDLE: begin
            busy        = 1'b0;
            ctl.capture = start;
         end
         aet_pkg::ST_EXEC:  ctl.execute = 1'b1;
         aet_pkg::ST_FETCH: ctl.fetch   = 1'b1;
         aet_pkg::ST_REPLY: ctl.reply   = 1'b1;
         default:           busy        = 1'b1;
      endcase
   end

endmodule

### sv/aet_datapath.sv
// ----------------------------------------------------------------------------
// aet_datapath
// word stack, input position, head marks and head/label store
// ----------------------------------------------------------------------------
module aet_datapath #(
   parameter int MAX_WORDS   = aet_pkg::MAX_WORDS_DEF,
   parameter int STACK_DEPTH = aet_pkg::STACK_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  aet_pkg::ctl_cmd_type ctl,
   input  aet_pkg::req_type     req_word,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   output logic                 rsp_strobe,
   output aet_pkg::rsp_type     rsp_word
);

   localparam int WA = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int SA = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SC = $clog2(STACK_DEPTH + 1);
   localparam int EW = (WA > 9) ? WA : 9;
   localparam logic [8:0]    InLimit   = 9'((MAX_WORDS < 256) ? MAX_WORDS : 256);
   localparam logic [EW:0]   WordLimit = (EW + 1)'(MAX_WORDS);
   localparam logic [SC-1:0] StackFull = SC'(STACK_DEPTH);

   typedef struct packed {
      logic [7:0] head;
      logic [7:0] label;
   } arc_entry_type;

   logic [7:0]             stack_mem [STACK_DEPTH];
   arc_entry_type          arc_mem   [MAX_WORDS];

   logic [7:0]             len_ff;
   aet_pkg::req_type       req_ff;
   logic [SC-1:0]          count_ff,    count_in;
   logic [7:0]             top_ff,      top_in;
   logic [8:0]             next_in_ff,  next_in_in;
   logic [8:0]             in_count_ff, in_count_in;
   logic [MAX_WORDS-1:0]   known_ff,    known_in;
   logic                   rej_ff,      rej_in;
   logic                   pop_ff,      pop_in;
   logic [7:0]             stack_rd_ff;
   arc_entry_type          arc_rd_ff;
   aet_pkg::rsp_type       rsp_ff,      rsp_in;
   logic                   rsp_strobe_ff;

   logic                   stack_we;
   logic [SA-1:0]          stack_wa;
   logic [7:0]             stack_wd;
   logic [SA-1:0]          stack_ra;
   logic                   arc_we;
   logic [WA-1:0]          arc_wa;
   arc_entry_type          arc_wd;

   logic                   empty, full, at_end;
   logic                   may_shift, may_reduce, may_left, may_right;
   logic [EW-1:0]          top_ext, w_ext, q_ext;
   logic [WA-1:0]          top_idx, w_idx, q_idx;
   logic                   top_ok, w_ok, q_ok;
   logic [SC-1:0]          cnt_m2;
   logic [SC+8:0]          cnt_wide;
   logic [8:0]             len_p1;
   logic                   q_valid;

   always_comb begin
      empty      = (count_ff == '0);
      full       = (count_ff >= StackFull);
      at_end     = (next_in_ff >= in_count_ff);
      top_ext    = EW'(top_ff);
      top_idx    = top_ext[WA-1:0];
      top_ok     = ({1'b0, top_ext} < WordLimit);
      w_ext      = EW'(next_in_ff);
      w_idx      = w_ext[WA-1:0];
      w_ok       = ({1'b0, w_ext} < WordLimit);
      q_ext      = EW'(req_ff.query_word);
      q_idx      = q_ext[WA-1:0];
      q_ok       = ({1'b0, q_ext} < WordLimit);
      may_shift  = !full && !at_end && ((next_in_ff + 9'd1) != in_count_ff);
      may_reduce = !empty && (top_ff != 8'd0);
      may_left   = !empty && !at_end && (top_ff != 8'd0) && top_ok && !known_ff[top_idx];
      may_right  = !empty && !full && !at_end;
      cnt_m2     = count_ff - SC'(2);
      cnt_wide   = (SC + 9)'(count_ff);
      len_p1     = {1'b0, len_ff} + 9'd1;
      q_valid    = q_ok && known_ff[q_idx];
   end

   // command execution, top reload after a pop
   always_comb begin
      count_in    = count_ff;
      top_in      = top_ff;
      next_in_in  = next_in_ff;
      in_count_in = in_count_ff;
      known_in    = known_ff;
      rej_in      = rej_ff;
      pop_in      = pop_ff;
      stack_we    = 1'b0;
      stack_wa    = count_ff[SA-1:0];
      stack_wd    = next_in_ff[7:0];
      stack_ra    = cnt_m2[SA-1:0];
      arc_we      = 1'b0;
      arc_wa      = top_idx;
      arc_wd      = '{head: next_in_ff[7:0], label: req_ff.arc_label};

      if (ctl.execute) begin
         rej_in = 1'b0;
         pop_in = 1'b0;
         case (req_ff.cmd)
            aet_pkg::CMD_START: begin
               in_count_in = (len_p1 > InLimit) ? InLimit : len_p1;
               known_in    = '0;
               stack_we    = 1'b1;
               stack_wa    = '0;
               stack_wd    = 8'd0;
               count_in    = SC'(1);
               top_in      = 8'd0;
               next_in_in  = 9'd1;
            end
            aet_pkg::CMD_SHIFT: begin
               if (may_shift) begin
                  stack_we   = 1'b1;
                  count_in   = count_ff + SC'(1);
                  top_in     = next_in_ff[7:0];
                  next_in_in = next_in_ff + 9'd1;
               end else begin
                  rej_in = 1'b1;
               end
            end
            aet_pkg::CMD_REDUCE: begin
               if (may_reduce) begin
                  count_in = count_ff - SC'(1);
                  pop_in   = 1'b1;
               end else begin
                  rej_in = 1'b1;
               end
            end
            aet_pkg::CMD_LEFT: begin
               if (may_left) begin
                  arc_we            = 1'b1;
                  known_in[top_idx] = 1'b1;
                  count_in          = count_ff - SC'(1);
                  pop_in            = 1'b1;
               end else begin
                  rej_in = 1'b1;
               end
            end
            aet_pkg::CMD_RIGHT: begin
               if (may_right) begin
                  if (w_ok) begin
                     arc_we          = 1'b1;
                     arc_wa          = w_idx;
                     arc_wd          = '{head: top_ff, label: req_ff.arc_label};
                     known_in[w_idx] = 1'b1;
                  end
                  stack_we   = 1'b1;
                  count_in   = count_ff + SC'(1);
                  top_in     = next_in_ff[7:0];
                  next_in_in = next_in_ff + 9'd1;
               end else begin
                  rej_in = 1'b1;
               end
            end
            aet_pkg::CMD_QUERY: rej_in = 1'b0;
            default:            rej_in = 1'b1;
         endcase
      end

      if (ctl.fetch && pop_ff) begin
         top_in = empty ? 8'd0 : stack_rd_ff;
         pop_in = 1'b0;
      end
   end

   always_comb begin
      rsp_in.allow_shift      = may_shift;
      rsp_in.allow_reduce     = may_reduce;
      rsp_in.allow_left_arc   = may_left;
      rsp_in.allow_right_arc  = may_right;
      rsp_in.stack_depth      = cnt_wide[8:0];
      rsp_in.stack_top_word   = top_ff;
      rsp_in.next_word_index  = next_in_ff;
      rsp_in.input_done       = at_end;
      rsp_in.rejected         = rej_ff;
      rsp_in.query_head       = q_valid ? arc_rd_ff.head : 8'd0;
      rsp_in.query_head_valid = q_valid;
      rsp_in.query_label      = q_valid ? arc_rd_ff.label : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= 8'd0;
         count_ff      <= '0;
         top_ff        <= 8'd0;
         next_in_ff    <= 9'd0;
         in_count_ff   <= 9'd0;
         known_ff      <= '0;
         rej_ff        <= 1'b0;
         pop_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
         count_ff      <= count_in;
         top_ff        <= top_in;
         next_in_ff    <= next_in_in;
         in_count_ff   <= in_count_in;
         known_ff      <= known_in;
         rej_ff        <= rej_in;
         pop_ff        <= pop_in;
         rsp_strobe_ff <= ctl.reply;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff <= req_word;
      end
      if (ctl.reply) begin
         rsp_ff <= rsp_in;
      end
   end

   // stack store
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      if (ctl.execute) begin
         stack_rd_ff <= stack_mem[stack_ra];
      end
   end

   // head and label store
   always_ff @(posedge clock) begin
      if (arc_we) begin
         arc_mem[arc_wa] <= arc_wd;
      end
      if (ctl.fetch) begin
         arc_rd_ff <= arc_mem[q_idx];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

`ifndef ASSERT_OFF
   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      ctl.execute && (req_ff.cmd == aet_pkg::CMD_START)
      |=> (count_ff == SC'(1)) && (next_in_ff == 9'd1) && (top_ff == 8'd0))
      else $error("start did not load root state");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      ctl.execute && rej_in |=> $stable(count_ff) && $stable(next_in_ff))
      else $error("rejected command changed the state");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      ctl.reply && (count_ff == '0) |-> (top_ff == 8'd0))
      else $error("empty stack shows a top word");

   a_input_bound: assert property (@(posedge clock) disable iff (reset)
      ctl.reply |-> (next_in_ff <= in_count_ff))
      else $error("input position beyond input size");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for two cycles");
`endif

endmodule
